@@ src/tqfg_pkg.sv @@
package tqfg_pkg;

  // Default field geometry
  localparam int ELEV_BITS_DEF       = 16;
  localparam int COORD_FRAC_BITS_DEF = 15;

  // Gradient output and configuration register geometry
  localparam int GRAD_BITS = 48;
  localparam int CFG_BITS  = 32;
  localparam int ADDR_BITS = 3;
  localparam int INV_SPLIT = 16;  // low partial-product slice of inv_spacing

  localparam logic [CFG_BITS-1:0] INV_RESET = 32'd65536;

  // Register index (paddr above the byte offset)
  localparam logic [ADDR_BITS-3:0] REG_INV_SPACING = 1'b0;

  // Saturation limits of the gradient outputs
  localparam logic [GRAD_BITS-1:0] GRAD_MAX = {1'b0, {(GRAD_BITS-1){1'b1}}};
  localparam logic [GRAD_BITS-1:0] GRAD_MIN = {1'b1, {(GRAD_BITS-1){1'b0}}};

  // Coefficient slots, in output order
  localparam int NUM_COEF = 9;
  localparam int Q_X2Y2   = 0;
  localparam int Q_X2Y    = 1;
  localparam int Q_XY2    = 2;
  localparam int Q_X2     = 3;
  localparam int Q_Y2     = 4;
  localparam int Q_XY     = 5;
  localparam int Q_X      = 6;
  localparam int Q_Y      = 7;
  localparam int Q_CONST  = 8;

endpackage

@@ src/tqfg_horner.sv @@
module tqfg_horner import tqfg_pkg::*; #(
  parameter int FRAC   = COORD_FRAC_BITS_DEF,
  parameter int P_BITS = ELEV_BITS_DEF + 5 + COORD_FRAC_BITS_DEF + 2
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [P_BITS-1:0]    p2,
  input  logic signed [P_BITS-1:0]    p1,
  input  logic signed [P_BITS-1:0]    p0,
  input  logic signed [FRAC:0]        w,
  input  logic        [CFG_BITS-1:0]  inv_spacing,
  output logic signed [GRAD_BITS-1:0] grad
);

  localparam int T_BITS  = P_BITS + 1;
  localparam int G_BITS  = P_BITS + 2;
  localparam int M1_BITS = P_BITS + FRAC + 1;
  localparam int M2_BITS = T_BITS + FRAC + 1;
  localparam int HI_W    = CFG_BITS - INV_SPLIT;
  localparam int LO_BITS = G_BITS + INV_SPLIT + 1;
  localparam int HI_BITS = G_BITS + HI_W + 1;
  localparam int S_BITS  = G_BITS + CFG_BITS + 2;

  localparam logic signed [M1_BITS-1:0] RND1 = {{(M1_BITS-1){1'b0}}, 1'b1} << (FRAC - 1);
  localparam logic signed [M2_BITS-1:0] RND2 = {{(M2_BITS-1){1'b0}}, 1'b1} << (FRAC - 1);
  localparam logic signed [S_BITS-1:0]  RND3 = {{(S_BITS-1){1'b0}}, 1'b1} << (FRAC - 1);

  logic signed [M1_BITS-1:0] prod1;
  logic signed [M1_BITS-1:0] rnd1;
  logic signed [T_BITS-1:0]  t_next;
  logic signed [T_BITS-1:0]  t;
  logic signed [P_BITS-1:0]  p0_d;
  logic signed [FRAC:0]      w_d;
  logic signed [M2_BITS-1:0] prod2;
  logic signed [M2_BITS-1:0] rnd2;
  logic signed [G_BITS-1:0]  g_next;
  logic signed [G_BITS-1:0]  g;
  logic signed [LO_BITS-1:0] pp_lo_next;
  logic signed [HI_BITS-1:0] pp_hi_next;
  logic signed [LO_BITS-1:0] pp_lo;
  logic signed [HI_BITS-1:0] pp_hi;
  logic signed [S_BITS-1:0]  sum;
  logic signed [S_BITS-1:0]  rsum;
  logic signed [GRAD_BITS-1:0] grad_next;

  // Horner step one: t = R(p2*w) + p1
  assign prod1  = p2 * w;
  assign rnd1   = (prod1 + RND1) >>> FRAC;
  assign t_next = rnd1[T_BITS-1:0] + T_BITS'(p1);

  // Horner step two: g = R(t*w) + p0
  assign prod2  = t * w_d;
  assign rnd2   = (prod2 + RND2) >>> FRAC;
  assign g_next = rnd2[G_BITS-1:0] + G_BITS'(p0_d);

  // Spacing scale as two partial products
  assign pp_lo_next = g * $signed({1'b0, inv_spacing[INV_SPLIT-1:0]});
  assign pp_hi_next = g * $signed({1'b0, inv_spacing[CFG_BITS-1:INV_SPLIT]});

  // Combine, round and saturate
  assign sum  = (S_BITS'(pp_hi) <<< INV_SPLIT) + S_BITS'(pp_lo);
  assign rsum = (sum + RND3) >>> FRAC;

  always_comb begin
    if ((&rsum[S_BITS-1:GRAD_BITS-1]) || !(|rsum[S_BITS-1:GRAD_BITS-1])) begin
      grad_next = rsum[GRAD_BITS-1:0];
    end else if (rsum[S_BITS-1]) begin
      grad_next = GRAD_MIN;
    end else begin
      grad_next = GRAD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t     <= t_next;
      p0_d  <= p0;
      w_d   <= w;
      g     <= g_next;
      pp_lo <= pp_lo_next;
      pp_hi <= pp_hi_next;
      grad  <= grad_next;
    end
  end

endmodule

@@ src/terrain_quadric_fit_gradient.sv @@
// Terrain quadric fit and gradient.
// Requests arrive on in_valid/in_ready: a 3x3 elevation window plus a query
// point (u,v) in grid steps from the centre. Each request yields one result on
// out_valid/out_ready: nine quadric coefficients in quarter elevation units at
// unit spacing, and the x/y gradient at the query point scaled by inv_spacing
// and saturated to 48 bits.
// Throughput: one request per cycle unless the output stalls. Each result reaches
// out_valid through the six-register pipeline (fit, polynomial terms, two
// Horner steps, two spacing partial products, round/saturate).
// The whole pipeline advances together; when out_valid is high and out_ready
// low, every stage holds and in_ready drops in the same cycle, so nothing is
// dropped or repeated. Empty stages are filled as the pipeline moves.
// inv_spacing is written through the APB port (byte address 0) and must only
// change while no request is in flight; pready is always high.
// Reset (rst, synchronous) empties the pipeline and sets inv_spacing to 1.0
// (Q16.16).
module terrain_quadric_fit_gradient import tqfg_pkg::*; #(
  parameter int ELEV_BITS       = ELEV_BITS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_BITS-1:0]         paddr,
  input  logic [CFG_BITS-1:0]          pwdata,
  output logic [CFG_BITS-1:0]          prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ELEV_BITS-1:0]  elev_x0_y0,
  input  logic signed [ELEV_BITS-1:0]  elev_x0_y1,
  input  logic signed [ELEV_BITS-1:0]  elev_x0_y2,
  input  logic signed [ELEV_BITS-1:0]  elev_x1_y0,
  input  logic signed [ELEV_BITS-1:0]  elev_x1_y1,
  input  logic signed [ELEV_BITS-1:0]  elev_x1_y2,
  input  logic signed [ELEV_BITS-1:0]  elev_x2_y0,
  input  logic signed [ELEV_BITS-1:0]  elev_x2_y1,
  input  logic signed [ELEV_BITS-1:0]  elev_x2_y2,
  input  logic signed [COORD_FRAC_BITS:0] query_u,
  input  logic signed [COORD_FRAC_BITS:0] query_v,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ELEV_BITS+4:0]  coef_x2y2,
  output logic signed [ELEV_BITS+4:0]  coef_x2y,
  output logic signed [ELEV_BITS+4:0]  coef_xy2,
  output logic signed [ELEV_BITS+4:0]  coef_x2,
  output logic signed [ELEV_BITS+4:0]  coef_y2,
  output logic signed [ELEV_BITS+4:0]  coef_xy,
  output logic signed [ELEV_BITS+4:0]  coef_x,
  output logic signed [ELEV_BITS+4:0]  coef_y,
  output logic signed [ELEV_BITS+4:0]  coef_const,
  output logic signed [GRAD_BITS-1:0]  grad_x,
  output logic signed [GRAD_BITS-1:0]  grad_y
);

  localparam int COEF_BITS = ELEV_BITS + 5;
  localparam int CRD_BITS  = COORD_FRAC_BITS + 1;
  localparam int PROD_BITS = COEF_BITS + CRD_BITS;
  localparam int P_BITS    = COEF_BITS + COORD_FRAC_BITS + 2;
  localparam int STAGES    = 6;
  localparam int LAST      = STAGES - 1;

  logic [CFG_BITS-1:0] inv_spacing;
  logic                cfg_hit;
  logic                adv;
  logic [STAGES-1:0]   vld;

  logic signed [COEF_BITS-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [COEF_BITS-1:0] q_next [NUM_COEF];
  logic signed [COEF_BITS-1:0] q_pipe [STAGES][NUM_COEF];
  logic signed [CRD_BITS-1:0]  u_s;
  logic signed [CRD_BITS-1:0]  v_s;

  logic signed [PROD_BITS-1:0] q0u, q1u, q3u, q0v, q2v, q4v;
  logic signed [P_BITS-1:0]    px2, px1, px0, py2, py1, py0;
  logic signed [CRD_BITS-1:0]  wx, wy;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[ADDR_BITS-1:2] == REG_INV_SPACING);
  assign prdata  = cfg_hit ? inv_spacing : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_spacing <= INV_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      inv_spacing <= pwdata;
    end
  end

  // Pipeline advance: all stages move together unless the output is stalled
  assign adv       = !vld[LAST] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  // Quadric fit (quarter units)
  assign e00 = COEF_BITS'(elev_x0_y0);
  assign e01 = COEF_BITS'(elev_x0_y1);
  assign e02 = COEF_BITS'(elev_x0_y2);
  assign e10 = COEF_BITS'(elev_x1_y0);
  assign e11 = COEF_BITS'(elev_x1_y1);
  assign e12 = COEF_BITS'(elev_x1_y2);
  assign e20 = COEF_BITS'(elev_x2_y0);
  assign e21 = COEF_BITS'(elev_x2_y1);
  assign e22 = COEF_BITS'(elev_x2_y2);

  always_comb begin
    q_next[Q_X2Y2]  = (e00 + e02 + e20 + e22) - ((e01 + e10 + e12 + e21) <<< 1)
                      + (e11 <<< 2);
    q_next[Q_X2Y]   = (e02 + e22 - e00 - e20) - ((e12 - e10) <<< 1);
    q_next[Q_XY2]   = (e20 + e22 - e00 - e02) + ((e01 - e21) <<< 1);
    q_next[Q_X2]    = ((e01 + e21) <<< 1) - (e11 <<< 2);
    q_next[Q_Y2]    = ((e10 + e12) <<< 1) - (e11 <<< 2);
    q_next[Q_XY]    = e00 + e22 - e02 - e20;
    q_next[Q_X]     = (e21 - e01) <<< 1;
    q_next[Q_Y]     = (e12 - e10) <<< 1;
    q_next[Q_CONST] = e11 <<< 2;
  end

  // Coefficient pipeline; stage 0 also holds the query point
  always_ff @(posedge clk) begin
    if (adv) begin
      q_pipe[0] <= q_next;
      u_s       <= query_u;
      v_s       <= query_v;
      for (int k = 1; k < STAGES; k++) begin
        q_pipe[k] <= q_pipe[k-1];
      end
    end
  end

  // Polynomial terms in the Horner variable
  assign q0u = q_pipe[0][Q_X2Y2] * u_s;
  assign q1u = q_pipe[0][Q_X2Y]  * u_s;
  assign q3u = q_pipe[0][Q_X2]   * u_s;
  assign q0v = q_pipe[0][Q_X2Y2] * v_s;
  assign q2v = q_pipe[0][Q_XY2]  * v_s;
  assign q4v = q_pipe[0][Q_Y2]   * v_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      px2 <= (P_BITS'(q_pipe[0][Q_XY2]) <<< COORD_FRAC_BITS) + (P_BITS'(q0u) <<< 1);
      px1 <= (P_BITS'(q_pipe[0][Q_XY])  <<< COORD_FRAC_BITS) + (P_BITS'(q1u) <<< 1);
      px0 <= (P_BITS'(q_pipe[0][Q_X])   <<< COORD_FRAC_BITS) + (P_BITS'(q3u) <<< 1);
      py2 <= (P_BITS'(q_pipe[0][Q_X2Y]) <<< COORD_FRAC_BITS) + (P_BITS'(q0v) <<< 1);
      py1 <= (P_BITS'(q_pipe[0][Q_XY])  <<< COORD_FRAC_BITS) + (P_BITS'(q2v) <<< 1);
      py0 <= (P_BITS'(q_pipe[0][Q_Y])   <<< COORD_FRAC_BITS) + (P_BITS'(q4v) <<< 1);
      wx  <= v_s;
      wy  <= u_s;
    end
  end

  // Horner evaluation and spacing scale, one unit per axis
  tqfg_horner #(
    .FRAC   (COORD_FRAC_BITS),
    .P_BITS (P_BITS)
  ) u_horner_x (
    .clk         (clk),
    .en          (adv),
    .p2          (px2),
    .p1          (px1),
    .p0          (px0),
    .w           (wx),
    .inv_spacing (inv_spacing),
    .grad        (grad_x)
  );

  tqfg_horner #(
    .FRAC   (COORD_FRAC_BITS),
    .P_BITS (P_BITS)
  ) u_horner_y (
    .clk         (clk),
    .en          (adv),
    .p2          (py2),
    .p1          (py1),
    .p0          (py0),
    .w           (wy),
    .inv_spacing (inv_spacing),
    .grad        (grad_y)
  );

  // Coefficient outputs
  assign coef_x2y2  = q_pipe[LAST][Q_X2Y2];
  assign coef_x2y   = q_pipe[LAST][Q_X2Y];
  assign coef_xy2   = q_pipe[LAST][Q_XY2];
  assign coef_x2    = q_pipe[LAST][Q_X2];
  assign coef_y2    = q_pipe[LAST][Q_Y2];
  assign coef_xy    = q_pipe[LAST][Q_XY];
  assign coef_x     = q_pipe[LAST][Q_X];
  assign coef_y     = q_pipe[LAST][Q_Y];
  assign coef_const = q_pipe[LAST][Q_CONST];

  // Checks
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted request did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved during a stall");

  a_const_quarter: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> coef_const[1:0] == 2'b00)
    else $error("constant term is not a multiple of four");

  a_even_terms: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !coef_x[0] && !coef_y[0] && !coef_x2[0] && !coef_y2[0])
    else $error("linear or square term is odd");

endmodule
